// File: hdl/dos_pkg.sv
`default_nettype none

package dos_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam int DEFAULT_TIME_WIDTH  = 48;

   localparam int NOW_W   = 48;
   localparam int COORD_W = 16;
   localparam int INDEX_W = 6;
   localparam int DIV_W   = 32;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 4;

   localparam int TICKS_W  = 32;
   localparam int COUNT_W  = 7;
   localparam int REPEAT_W = 16;

   localparam logic [1:0] ACT_APPLY = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STOP  = 2'd2;
   localparam logic [1:0] ACT_WRITE = 2'd3;

   localparam logic [1:0] REG_STEP_TICKS    = 2'd0;
   localparam logic [1:0] REG_STEP_COUNT    = 2'd1;
   localparam logic [1:0] REG_REPEAT_COUNT  = 2'd2;
   localparam logic [1:0] REG_RELATIVE_MODE = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [NOW_W-1:0]   now_ticks;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [INDEX_W-1:0] entry_index;
      logic [COORD_W-1:0] entry_dx;
      logic [COORD_W-1:0] entry_dy;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic               dithering;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
   } entry_type;

endpackage

`default_nettype wire

// File: hdl/dos_divider.sv
`default_nettype none

module dos_divider #(
   parameter int NUM_W = dos_pkg::DEFAULT_TIME_WIDTH,
   parameter int DEN_W = dos_pkg::DIV_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient,
   output logic [DEN_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             take;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      take  = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], take};
         rem_in = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: hdl/dither_offset_sequencer.sv
`default_nettype none

// Dither offset sequencer. Start, stop and table writes are one transaction each and
// answer with a result in the cycle after acceptance; busy stays low, so the next transaction
// can follow at once. An apply transaction holds busy high while the elapsed time is
// divided by step_ticks and the step number then by step_count in one shared divider that
// retires a single quotient bit per cycle, followed by a read of the pattern table unless
// the repeat_count is used up. The result is shown for exactly one cycle with rsp_strobe and
// cannot be held off, so the receiver must take it in that cycle. Table entries read
// before they were written give undefined offsets.

module dither_offset_sequencer #(
   parameter int TABLE_DEPTH = dos_pkg::DEFAULT_TABLE_DEPTH,
   parameter int TIME_WIDTH  = dos_pkg::DEFAULT_TIME_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire dos_pkg::req_type           req_data,
   output logic                            rsp_strobe,
   output dos_pkg::rsp_type                rsp_data,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [dos_pkg::ADDR_W-1:0] paddr,
   input  wire logic [dos_pkg::CSR_W-1:0]  pwdata,
   output logic [dos_pkg::CSR_W-1:0]       prdata,
   output logic                            pready
);

   import dos_pkg::*;

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TBL_CW = $clog2(TABLE_DEPTH + 1);
   localparam int CNT_W  = (TBL_CW > COUNT_W) ? TBL_CW : COUNT_W;

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_DIV_STEP = 2'd1;
   localparam logic [1:0] ST_DIV_REP  = 2'd2;
   localparam logic [1:0] ST_READ     = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [TIME_WIDTH-1:0] start_time_ff, start_time_in;
   logic                  active_ff, active_in;
   logic [COORD_W-1:0]    coord_x_ff, coord_x_in;
   logic [COORD_W-1:0]    coord_y_ff, coord_y_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [TICKS_W-1:0]    step_ticks_ff, step_ticks_in;
   logic [COUNT_W-1:0]    step_count_ff, step_count_in;
   logic [REPEAT_W-1:0]   repeat_count_ff, repeat_count_in;
   logic                  relative_mode_ff, relative_mode_in;

   entry_type             table_mem [TABLE_DEPTH];
   entry_type             rd_entry_ff;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic                  mem_re;
   logic [IDX_W-1:0]      mem_raddr;

   logic                  accept;
   logic                  csr_write;
   logic [TIME_WIDTH-1:0] now_ext;
   logic [TICKS_W-1:0]    ticks_eff;
   logic [CNT_W-1:0]      count_ext;
   logic [CNT_W-1:0]      count_eff;
   logic                  rep_hit;

   logic                  div_go;
   logic [TIME_WIDTH-1:0] div_dividend;
   logic [DIV_W-1:0]      div_divisor;
   logic                  div_done;
   logic [TIME_WIDTH-1:0] div_quo;
   logic [DIV_W-1:0]      div_rem;

   dos_divider #(
      .NUM_W(TIME_WIDTH),
      .DEN_W(DIV_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      now_ext   = TIME_WIDTH'(req_data.now_ticks);
      ticks_eff = (step_ticks_ff == '0) ? TICKS_W'(1) : step_ticks_ff;
      count_ext = CNT_W'(step_count_ff);
      if (count_ext == '0) begin
         count_eff = CNT_W'(1);
      end else if (count_ext > CNT_W'(TABLE_DEPTH)) begin
         count_eff = CNT_W'(TABLE_DEPTH);
      end else begin
         count_eff = count_ext;
      end
      rep_hit = (repeat_count_ff == '0) || (div_quo < TIME_WIDTH'(repeat_count_ff));
   end

   // configuration registers
   always_comb begin
      step_ticks_in    = step_ticks_ff;
      step_count_in    = step_count_ff;
      repeat_count_in  = repeat_count_ff;
      relative_mode_in = relative_mode_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            REG_STEP_TICKS:    step_ticks_in    = pwdata[TICKS_W-1:0];
            REG_STEP_COUNT:    step_count_in    = pwdata[COUNT_W-1:0];
            REG_REPEAT_COUNT:  repeat_count_in  = pwdata[REPEAT_W-1:0];
            REG_RELATIVE_MODE: relative_mode_in = pwdata[0];
            default:           step_ticks_in    = step_ticks_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_STEP_TICKS:    prdata = CSR_W'(step_ticks_ff);
         REG_STEP_COUNT:    prdata = CSR_W'(step_count_ff);
         REG_REPEAT_COUNT:  prdata = CSR_W'(repeat_count_ff);
         REG_RELATIVE_MODE: prdata = CSR_W'(relative_mode_ff);
         default:           prdata = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      start_time_in = start_time_ff;
      active_in     = active_ff;
      coord_x_in    = coord_x_ff;
      coord_y_in    = coord_y_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      div_go        = 1'b0;
      div_dividend  = now_ext - start_time_ff;
      div_divisor   = ticks_eff;
      mem_we        = 1'b0;
      mem_waddr     = IDX_W'(req_data.entry_index);
      mem_re        = 1'b0;
      mem_raddr     = IDX_W'(div_rem);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               coord_x_in = req_data.coord_x;
               coord_y_in = req_data.coord_y;
               unique case (req_data.action)
                  ACT_APPLY: begin
                     div_go   = 1'b1;
                     state_in = ST_DIV_STEP;
                  end
                  ACT_START: begin
                     start_time_in = now_ext;
                     active_in     = 1'b1;
                  end
                  ACT_STOP: begin
                     active_in = 1'b0;
                  end
                  ACT_WRITE: begin
                     mem_we = (32'(req_data.entry_index) < 32'(TABLE_DEPTH));
                  end
                  default: begin
                     active_in = active_ff;
                  end
               endcase
               if (req_data.action != ACT_APPLY) begin
                  rsp_strobe_in         = 1'b1;
                  rsp_data_in.out_x     = req_data.coord_x;
                  rsp_data_in.out_y     = req_data.coord_y;
                  rsp_data_in.dithering = active_in;
               end
            end
         end
         ST_DIV_STEP: begin
            if (div_done) begin
               div_go       = 1'b1;
               div_dividend = div_quo;
               div_divisor  = DIV_W'(count_eff);
               state_in     = ST_DIV_REP;
            end
         end
         ST_DIV_REP: begin
            if (div_done) begin
               if (rep_hit) begin
                  mem_re   = 1'b1;
                  state_in = ST_READ;
               end else begin
                  active_in             = 1'b0;
                  rsp_strobe_in         = 1'b1;
                  rsp_data_in.out_x     = coord_x_ff;
                  rsp_data_in.out_y     = coord_y_ff;
                  rsp_data_in.dithering = 1'b0;
                  state_in              = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in.out_x     = relative_mode_ff ? coord_x_ff + rd_entry_ff.dx
                                                     : rd_entry_ff.dx;
            rsp_data_in.out_y     = relative_mode_ff ? coord_y_ff + rd_entry_ff.dy
                                                     : rd_entry_ff.dy;
            rsp_data_in.dithering = active_ff;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         start_time_ff    <= '0;
         active_ff        <= 1'b0;
         rsp_strobe_ff    <= 1'b0;
         step_ticks_ff    <= TICKS_W'(1);
         step_count_ff    <= COUNT_W'(1);
         repeat_count_ff  <= '0;
         relative_mode_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         start_time_ff    <= start_time_in;
         active_ff        <= active_in;
         rsp_strobe_ff    <= rsp_strobe_in;
         step_ticks_ff    <= step_ticks_in;
         step_count_ff    <= step_count_in;
         repeat_count_ff  <= repeat_count_in;
         relative_mode_ff <= relative_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      coord_x_ff  <= coord_x_in;
      coord_y_ff  <= coord_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   // pattern table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= {req_data.entry_dx, req_data.entry_dy};
      end
      if (mem_re) begin
         rd_entry_ff <= table_mem[mem_raddr];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire
